/* design/acd_pkg.sv */
// ----------------------------------------------------------------------------
// acd_pkg
// shared constants and types of the axis calibration and deadzone block
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int DEF_RAW_WIDTH = 16;
   localparam int DEF_FRAC_BITS = 16;
   localparam int SPAN_WIDTH    = 16;
   localparam int SHIFT_WIDTH   = 17;
   localparam int CSR_WIDTH     = 17;
   localparam int CSR_IDX_W     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPAN_LOW     = 3'd0,
      REG_SPAN_HIGH    = 3'd1,
      REG_DEAD_BAND    = 3'd2,
      REG_CENTER_SHIFT = 3'd3,
      REG_REVERSE      = 3'd4
   } csr_index_type;

   // zone of a linear position relative to the deadzone band
   typedef enum logic [1:0] {
      ZONE_PASS   = 2'd0,
      ZONE_BELOW  = 2'd1,
      ZONE_ABOVE  = 2'd2,
      ZONE_INSIDE = 2'd3
   } zone_type;

   // flags that ride along the linear-map divider
   typedef struct packed {
      logic zero;
      logic ovf;
   } lin_flags_type;

endpackage

/* design/acd_if.sv */
// ----------------------------------------------------------------------------
// acd_req_if / acd_rsp_if
// valid/ready channels carrying raw samples and conditioned positions
// ----------------------------------------------------------------------------
interface acd_req_if #(
   parameter int RAW_WIDTH = 16
);
   logic                 valid;
   logic                 ready;
   logic [RAW_WIDTH-1:0] raw_position;

   modport source (output valid, output raw_position, input ready);
   modport sink   (input valid, input raw_position, output ready);
endinterface

interface acd_rsp_if #(
   parameter int FRAC_BITS = 16
);
   logic               valid;
   logic               ready;
   logic [FRAC_BITS:0] position;
   logic [FRAC_BITS:0] position_linear;

   modport source (output valid, output position, output position_linear, input ready);
   modport sink   (input valid, input position, input position_linear, output ready);
endinterface

/* design/axis_calibrate_center_deadzone.sv */
// ----------------------------------------------------------------------------
// axis_calibrate_center_deadzone
// steering-axis calibration with a shifted center deadzone
// ----------------------------------------------------------------------------
// Takes one raw axis sample per transfer and returns its linear position over
// the calibrated span plus the deadzone-conditioned position, both Q(FRAC_BITS)
// in 0..1 and optionally mirrored. One sample can be taken every cycle while no
// result stalls. The pipe holds two pipelined restoring dividers (FRAC_BITS+1
// quotient stages for the span map, FRAC_BITS for the deadzone stretch) and
// three stages of pre- and post-processing. Every stage is elastic, so a stalled
// result leaves earlier stages filling. The user must write registers through
// csr_we/csr_index/csr_wdata only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module axis_calibrate_center_deadzone #(
   parameter int RAW_WIDTH = acd_pkg::DEF_RAW_WIDTH,
   parameter int FRAC_BITS = acd_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   acd_req_if.sink                        req_chan,
   acd_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [acd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [acd_pkg::CSR_WIDTH-1:0]  csr_wdata
);

   import acd_pkg::*;

   localparam int AW    = (RAW_WIDTH > SPAN_WIDTH) ? RAW_WIDTH : SPAN_WIDTH;
   localparam int OW    = FRAC_BITS + 1;
   localparam int LW    = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
   localparam int ONE_I = 1 << FRAC_BITS;
   localparam int DZ_MIN_I = (ONE_I * 5) / 1000;
   // span divider
   localparam int NW1 = AW + FRAC_BITS + 1;
   localparam int QW1 = FRAC_BITS + 1;
   localparam int SB1W = $bits(lin_flags_type);
   // deadzone divider
   localparam int DW2 = LW - 1;
   localparam int NW2 = DW2 + FRAC_BITS;
   localparam int QW2 = FRAC_BITS;
   localparam int SB2W = $bits(zone_type) + OW;

   localparam logic [OW-1:0] ONE  = OW'(ONE_I);
   localparam logic [OW-1:0] HALF = OW'(ONE_I / 2);
   localparam logic signed [LW-1:0] ONE_S  = LW'(ONE_I);
   localparam logic signed [LW-1:0] HALF_S = LW'(ONE_I / 2);

   // configuration registers
   logic [SPAN_WIDTH-1:0]         span_low_ff, span_high_ff, dead_band_ff;
   logic signed [SHIFT_WIDTH-1:0] center_shift_ff;
   logic                          reverse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_low_ff     <= '0;
         span_high_ff    <= '1;
         dead_band_ff    <= '0;
         center_shift_ff <= '0;
         reverse_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_SPAN_LOW:     span_low_ff     <= csr_wdata[SPAN_WIDTH-1:0];
            REG_SPAN_HIGH:    span_high_ff    <= csr_wdata[SPAN_WIDTH-1:0];
            REG_DEAD_BAND:    dead_band_ff    <= csr_wdata[SPAN_WIDTH-1:0];
            REG_CENTER_SHIFT: center_shift_ff <= $signed(csr_wdata[SHIFT_WIDTH-1:0]);
            REG_REVERSE:      reverse_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // band limits; the user must keep them static while items are in flight (not enforced)
   logic signed [LW-1:0] center, band_lo, band_hi, room_hi;
   logic                 dz_en;

   assign center  = HALF_S + LW'(center_shift_ff);
   assign band_lo = center - $signed(LW'(dead_band_ff));
   assign band_hi = center + $signed(LW'(dead_band_ff));
   assign room_hi = ONE_S - band_hi;
   assign dz_en   = (32'(dead_band_ff) > 32'(DZ_MIN_I));

   // ---------------- stage 1: span offset and magnitudes ----------------
   logic signed [AW:0] diff;
   logic signed [SPAN_WIDTH:0] den;
   logic               zero_c;
   logic [AW-1:0]      mag_c;
   logic [SPAN_WIDTH-1:0] dmag_c;

   assign diff   = $signed((AW+1)'(req_chan.raw_position)) - $signed((AW+1)'(span_low_ff));
   assign den    = $signed({1'b0, span_high_ff}) - $signed({1'b0, span_low_ff});
   assign mag_c  = diff[AW] ? AW'(-diff) : AW'(diff);
   assign dmag_c = den[SPAN_WIDTH] ? SPAN_WIDTH'(-den) : SPAN_WIDTH'(den);
   // zero-width span, sample on span_low, or sample on the far side
   assign zero_c = (den == '0) || (diff == '0) || (diff[AW] != den[SPAN_WIDTH]);

   logic                  s1_v_ff;
   logic [AW-1:0]         s1_mag_ff;
   logic [SPAN_WIDTH-1:0] s1_dmag_ff;
   logic                  s1_zero_ff;
   logic                  s1_rdy, div1_in_ready;

   assign s1_rdy         = !s1_v_ff || div1_in_ready;
   assign req_chan.ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_mag_ff  <= mag_c;
         s1_dmag_ff <= dmag_c;
         s1_zero_ff <= zero_c;
      end
   end

   // rounded numerator and saturation check for the span division
   logic [NW1-1:0] num1, lim1;
   lin_flags_type  flags1_in, flags1_out;

   assign num1 = (NW1'(s1_mag_ff) << FRAC_BITS) + NW1'(s1_dmag_ff >> 1);
   assign lim1 = NW1'(s1_dmag_ff) << (FRAC_BITS + 1);
   assign flags1_in.zero = s1_zero_ff;
   assign flags1_in.ovf  = (num1 >= lim1);

   logic           div1_out_valid, s2_rdy;
   logic [QW1-1:0] quo1;

   acd_div_pipe #(
      .NW (NW1), .DW (SPAN_WIDTH), .QW (QW1), .SBW (SB1W)
   ) u_div_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_ready  (div1_in_ready),
      .in_num    (num1),
      .in_den    (s1_dmag_ff),
      .in_sb     (flags1_in),
      .out_valid (div1_out_valid),
      .out_ready (s2_rdy),
      .out_quo   (quo1),
      .out_sb    (flags1_out)
   );

   // ---------------- stage 2: linear position and zone ----------------
   logic [OW-1:0]        lin_c;
   logic signed [LW-1:0] lin_s;
   zone_type             zone_c;

   always_comb begin
      if (flags1_out.zero) begin
         lin_c = '0;
      end else if (flags1_out.ovf || quo1 > ONE) begin
         lin_c = ONE;
      end else begin
         lin_c = quo1;
      end
   end

   assign lin_s = $signed(LW'(lin_c));

   always_comb begin
      if (!dz_en) begin
         zone_c = ZONE_PASS;
      end else if (lin_s < band_lo) begin
         zone_c = ZONE_BELOW;
      end else if (lin_s > band_hi) begin
         zone_c = ZONE_ABOVE;
      end else begin
         zone_c = ZONE_INSIDE;
      end
   end

   logic          s2_v_ff;
   logic [OW-1:0] s2_lin_ff;
   zone_type      s2_zone_ff;
   logic          div2_in_ready;

   assign s2_rdy = !s2_v_ff || div2_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= div1_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_lin_ff  <= lin_c;
         s2_zone_ff <= zone_c;
      end
   end

   // stretch operands: below band lin/lo, above band (lin-hi)/(1-hi), scaled by one half
   logic [OW-1:0]        over_hi;
   logic signed [LW-1:0] lin_minus_hi;
   logic [OW-1:0]        part2;
   logic [DW2-1:0]       den2;
   logic [NW2-1:0]       num2;

   assign lin_minus_hi = $signed(LW'(s2_lin_ff)) - band_hi;
   assign over_hi      = lin_minus_hi[OW-1:0];

   always_comb begin
      case (s2_zone_ff)
         ZONE_BELOW: begin
            part2 = s2_lin_ff;
            den2  = band_lo[DW2-1:0];
         end
         ZONE_ABOVE: begin
            part2 = over_hi;
            den2  = room_hi[DW2-1:0];
         end
         default: begin
            part2 = '0;
            den2  = DW2'(1);
         end
      endcase
   end

   assign num2 = (NW2'(part2) << (FRAC_BITS - 1)) + NW2'(den2 >> 1);

   logic            div2_out_valid, s3_rdy;
   logic [QW2-1:0]  quo2;
   logic [SB2W-1:0] sb2_out;

   acd_div_pipe #(
      .NW (NW2), .DW (DW2), .QW (QW2), .SBW (SB2W)
   ) u_div_zone (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_ready  (div2_in_ready),
      .in_num    (num2),
      .in_den    (den2),
      .in_sb     ({s2_zone_ff, s2_lin_ff}),
      .out_valid (div2_out_valid),
      .out_ready (s3_rdy),
      .out_quo   (quo2),
      .out_sb    (sb2_out)
   );

   // ---------------- stage 3: conditioned position, mirror, output ----------------
   zone_type      zone3;
   logic [OW-1:0] lin3, pos_c, above_c, pos_o, lin_o;

   assign zone3   = zone_type'(sb2_out[SB2W-1 -: $bits(zone_type)]);
   assign lin3    = sb2_out[OW-1:0];
   assign above_c = HALF + OW'(quo2);

   always_comb begin
      case (zone3)
         ZONE_PASS:   pos_c = lin3;
         ZONE_INSIDE: pos_c = HALF;
         ZONE_BELOW:  pos_c = (OW'(quo2) > ONE) ? ONE : OW'(quo2);
         ZONE_ABOVE:  pos_c = (above_c > ONE) ? ONE : above_c;
         default:     pos_c = lin3;
      endcase
   end

   assign pos_o = reverse_ff ? ONE - pos_c : pos_c;
   assign lin_o = reverse_ff ? ONE - lin3 : lin3;

   logic          out_v_ff;
   logic [OW-1:0] out_pos_ff, out_lin_ff;

   assign s3_rdy = !out_v_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         out_v_ff <= div2_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         out_pos_ff <= pos_o;
         out_lin_ff <= lin_o;
      end
   end

   // result transfer
   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.position        = out_pos_ff;
   assign rsp_chan.position_linear = out_lin_ff;

endmodule

/* design/acd_div_pipe.sv */
// ----------------------------------------------------------------------------
// acd_div_pipe
// pipelined restoring divider, one quotient bit per elastic stage
// ----------------------------------------------------------------------------
module acd_div_pipe #(
   parameter int NW  = 33,
   parameter int DW  = 16,
   parameter int QW  = 17,
   parameter int SBW = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SBW-1:0] in_sb,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [QW-1:0] out_quo,
   output logic [SBW-1:0] out_sb
);

   localparam int RW = (NW > DW + QW) ? NW : DW + QW;

   logic          v_ff   [QW];
   logic [RW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [SBW-1:0] sb_ff [QW];
   logic [QW:0]   rdy;

   assign rdy[QW] = out_ready;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;
      logic          v_src;
      logic [RW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] quo_src;
      logic [SBW-1:0] sb_src;
      logic [RW-1:0] trial;
      logic          hit;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = RW'(in_num);
         assign den_src = in_den;
         assign quo_src = '0;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign sb_src  = sb_ff[k-1];
      end

      assign trial  = RW'(den_src) << SH;
      assign hit    = (rem_src >= trial);
      assign rdy[k] = !v_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            rem_ff[k] <= hit ? rem_src - trial : rem_src;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_src | (hit ? (QW'(1) << SH) : '0);
            sb_ff[k]  <= sb_src;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_sb    = sb_ff[QW-1];

endmodule

/* design/acd_checker.sv */
// ----------------------------------------------------------------------------
// acd_checker
// port-level checks on the result channel of the calibration block
// ----------------------------------------------------------------------------
module acd_checker #(
   parameter int FRAC_BITS = acd_pkg::DEF_FRAC_BITS
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FRAC_BITS:0] position,
   input logic [FRAC_BITS:0] position_linear
);

   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (position <= ONE) && (position_linear <= ONE))
      else $error("result outside 0..1");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(position)
                                  && $stable(position_linear))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind axis_calibrate_center_deadzone acd_checker #(.FRAC_BITS(FRAC_BITS)) u_acd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .position        (rsp_chan.position),
   .position_linear (rsp_chan.position_linear)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the axis calibration and center deadzone block
// ----------------------------------------------------------------------------
// Drives raw samples through the request channel with random gaps, stalls the
// response channel at random, and compares every response transfer with a
// predicted linear and conditioned position. Register settings are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import acd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE      = 65536;
   localparam longint HALF     = ONE / 2;
   localparam longint DZ_FLOOR = (ONE * 5) / 1000;
   localparam int     LATENCY  = 36;
   localparam int     LIMIT    = 400000;

   typedef struct {
      logic [16:0] position;
      logic [16:0] position_linear;
   } axis_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   acd_req_if #(.RAW_WIDTH(16)) req_chan ();
   acd_rsp_if #(.FRAC_BITS(16)) rsp_chan ();

   axis_calibrate_center_deadzone i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   longint cal_low, cal_high, cal_band, cal_shift;
   bit     cal_rev;

   axis_result_type pending_positions[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int cycles = 0;

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.raw_position = '0;
      rsp_chan.ready = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
   endtask

   function automatic longint round_div(input longint n, input longint d);
      return (n + d / 2) / d;
   endfunction

   function automatic longint clip_unit(input longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
   endfunction

   function automatic axis_result_type predict_position(input logic [15:0] raw);
      axis_result_type r;
      longint num, den, lin, pos, ctr, lo, hi;
      num = (longint'(raw) - cal_low) * ONE;
      den = cal_high - cal_low;
      // zero span, zero offset or opposite signs give 0
      if (den == 0 || num == 0 || ((num < 0) != (den < 0))) lin = 0;
      else begin
         if (num < 0) num = -num;
         if (den < 0) den = -den;
         lin = clip_unit(round_div(num, den));
      end
      if (cal_band <= DZ_FLOOR) pos = lin;
      else begin
         ctr = HALF + cal_shift;
         lo = ctr - cal_band;
         hi = ctr + cal_band;
         if (lin < lo) pos = clip_unit(round_div(lin * HALF, lo));
         else if (lin > hi) pos = clip_unit(HALF + round_div((lin - hi) * HALF, ONE - hi));
         else pos = HALF;
      end
      if (cal_rev) begin
         pos = ONE - pos;
         lin = ONE - lin;
      end
      r.position = pos[16:0];
      r.position_linear = lin[16:0];
      return r;
   endfunction

   // response side: random stalls, then compare against oldest prediction
   initial begin
      axis_result_type want;
      int stall;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (pending_positions.size() == 0) begin
            report("unexpected response transfer", 1, 0);
         end else begin
            want = pending_positions.pop_front();
            if (rsp_chan.position !== want.position)
               report("position", rsp_chan.position, want.position);
            if (rsp_chan.position_linear !== want.position_linear)
               report("position_linear", rsp_chan.position_linear, want.position_linear);
         end
         checked++;
      end
   end

   task automatic write_reg(input csr_index_type idx, input longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_WIDTH-1:0];
      @(posedge clock);
      case (idx)
         REG_SPAN_LOW:     cal_low = value & 16'hFFFF;
         REG_SPAN_HIGH:    cal_high = value & 16'hFFFF;
         REG_DEAD_BAND:    cal_band = value & 16'hFFFF;
         REG_CENTER_SHIFT: cal_shift = longint'($signed(value[16:0]));
         REG_REVERSE:      cal_rev = value[0];
         default: ;
      endcase
   endtask

   task automatic set_calibration(input longint lo, input longint hi, input longint band,
                                  input longint shift, input bit rev);
      write_reg(REG_SPAN_LOW, lo);
      write_reg(REG_SPAN_HIGH, hi);
      write_reg(REG_DEAD_BAND, band);
      write_reg(REG_CENTER_SHIFT, shift);
      write_reg(REG_REVERSE, longint'(rev));
      csr_we <= 1'b0;
   endtask

   // one request transfer, with a random idle gap before it unless back to back
   task automatic send_sample(input logic [15:0] raw, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.raw_position <= raw;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_positions.push_back(predict_position(raw));
      sent++;
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // extremes of the span and of the input, with the deadzone off
   task automatic test_linear_extremes;
      set_calibration(0, 65535, 0, 0, 0);
      send_sample(16'h0000, 0);
      send_sample(16'hFFFF, 0);
      send_sample(16'h8000, 0);
      send_sample(16'h7FFF, 0);
      drain();
      set_calibration(1000, 60000, 327, 0, 0);   // band just at the enable floor
      send_sample(500, 0);
      send_sample(1000, 0);
      send_sample(60000, 0);
      send_sample(65535, 0);
      drain();
   endtask

   // zero-width and reversed spans
   task automatic test_span_cases;
      set_calibration(20000, 20000, 4000, 0, 0);
      send_sample(19999, 0);
      send_sample(20000, 0);
      send_sample(20001, 0);
      drain();
      set_calibration(60000, 5000, 0, 0, 1);
      send_sample(5000, 0);
      send_sample(30000, 0);
      send_sample(65535, 0);
      drain();
   endtask

   // below, inside and above the band, shifted centers and widest band
   task automatic test_deadzone_zones;
      set_calibration(0, 65535, 328, 0, 0);
      send_sample(16'h7F00, 0);
      send_sample(16'h8000, 0);
      send_sample(16'h8200, 0);
      drain();
      set_calibration(0, 65535, 8000, -32768, 1);  // band reaching below zero
      send_sample(0, 0);
      send_sample(30000, 0);
      drain();
      set_calibration(0, 65535, 8000, 32768, 0);   // band reaching past one
      send_sample(65535, 0);
      send_sample(30000, 0);
      drain();
      set_calibration(0, 65535, 32768, 0, 0);
      send_sample(1, 0);
      send_sample(65534, 0);
      drain();
   endtask

   // random phases, mostly with an active deadzone
   task automatic test_random_samples;
      longint lo, hi, band, shift;
      bit burst;
      for (int phase = 0; phase < 10; phase++) begin
         lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
         hi = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
         if (phase == 3) hi = lo;
         band = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 32768);
         shift = longint'($urandom_range(0, 65536)) - 32768;
         set_calibration(lo, hi, band, shift, 1'($urandom_range(0, 1)));
         burst = 0;
         for (int k = 0; k < 50; k++) begin
            if ($urandom_range(0, 7) == 0) burst = ~burst;
            send_sample(16'($urandom_range(0, 65535)), burst);
         end
         drain();
      end
   endtask

   initial begin
      cal_low = 0; cal_high = 65535; cal_band = 0; cal_shift = 0; cal_rev = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_linear_extremes();
      test_span_cases();
      test_deadzone_zones();
      test_random_samples();
      $display("sent %0d samples, checked %0d results over spans, bands and mirroring",
               sent, checked);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
